/* hdl/fda_pkg.sv */
`default_nettype none

package fda_pkg;

  // Angle accumulator width, in units of 2^-16 degree (signed).
  localparam int ZW = 26;
  // Width of a finished angle; the rounded value before the wrap is QW bits wide.
  localparam int AW = 16;
  localparam int QW = ZW - 9;

  localparam int ATAN_LEN = 24;

  // atan(2^-i) in degrees times 2^16, rounded to nearest.
  localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  localparam logic [ZW-1:0] DEG180  = 26'd11796480;
  localparam logic [ZW-1:0] DEG360  = 26'd23592960;
  localparam logic [ZW-1:0] RND_HALF = 26'd256;
  localparam logic [QW-1:0] WRAP    = 17'd46080;

  // Lane order: 0 = yOz, 1 = xOz, 2 = xOy.
  localparam int LANES = 3;

  // Control that travels with each vector triple down the pipeline.
  typedef struct packed {
    logic              pv;
    logic [LANES-1:0]  zero;
  } fda_ctl_t;

endpackage

`default_nettype wire

/* hdl/fda_if.sv */
`default_nettype none

interface fda_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] force_x;
  logic signed [SAMPLE_WIDTH-1:0] force_y;
  logic signed [SAMPLE_WIDTH-1:0] force_z;
  logic                           point_valid;

  modport source (output valid, force_x, force_y, force_z, point_valid, input ready);
  modport sink   (input valid, force_x, force_y, force_z, point_valid, output ready);
endinterface

interface fda_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_yz;
  logic [15:0] angle_xz;
  logic [15:0] angle_xy;
  logic        result_valid;

  modport source (output valid, angle_yz, angle_xz, angle_xy, result_valid, input ready);
  modport sink   (input valid, angle_yz, angle_xz, angle_xy, result_valid, output ready);
endinterface

`default_nettype wire

/* hdl/fda_pre.sv */
`default_nettype none

module fda_pre #(
  parameter int SW    = 24,
  parameter int W     = 43,
  parameter int STEPS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  fda_in_if.sink                                       in_ch,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output fda_pkg::fda_ctl_t                            out_ctl,
  output logic [fda_pkg::LANES-1:0][W-1:0]             out_u,
  output logic [fda_pkg::LANES-1:0][W-1:0]             out_v,
  output logic [fda_pkg::LANES-1:0][fda_pkg::ZW-1:0]   out_z
);
  import fda_pkg::*;

  logic signed [W-1:0] xs, ys, zs;
  logic signed [W-1:0] su [LANES];
  logic signed [W-1:0] sv [LANES];
  logic                valid_r;
  fda_ctl_t            ctl_nxt;
  logic [LANES-1:0][W-1:0]  u_nxt, v_nxt;
  logic [LANES-1:0][ZW-1:0] z_nxt;

  assign xs = W'($signed(in_ch.force_x[SW-1:0]));
  assign ys = W'($signed(in_ch.force_y[SW-1:0]));
  assign zs = W'($signed(in_ch.force_z[SW-1:0]));

  // Each lane is the pair (u, v) whose angle is atan2(v, u).
  assign su[0] = ys;
  assign sv[0] = zs;
  assign su[1] = xs;
  assign sv[1] = zs;
  assign su[2] = xs;
  assign sv[2] = ys;

  assign in_ch.ready = !valid_r || out_ready;

  always_comb begin
    ctl_nxt.pv = in_ch.point_valid;
    for (int k = 0; k < LANES; k++) begin
      ctl_nxt.zero[k] = (su[k] == '0) && (sv[k] == '0);
      // Left half-plane: rotate by 180 degrees first.
      if (su[k][W-1]) begin
        u_nxt[k] = (-su[k]) <<< STEPS;
        v_nxt[k] = (-sv[k]) <<< STEPS;
        z_nxt[k] = DEG180;
      end else begin
        u_nxt[k] = su[k] <<< STEPS;
        v_nxt[k] = sv[k] <<< STEPS;
        z_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      out_ctl <= ctl_nxt;
      out_u   <= u_nxt;
      out_v   <= v_nxt;
      out_z   <= z_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

/* hdl/fda_step.sv */
`default_nettype none

module fda_step #(
  parameter int W   = 43,
  parameter int IDX = 0
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire fda_pkg::fda_ctl_t                           in_ctl,
  input  wire logic [fda_pkg::LANES-1:0][W-1:0]            in_u,
  input  wire logic [fda_pkg::LANES-1:0][W-1:0]            in_v,
  input  wire logic [fda_pkg::LANES-1:0][fda_pkg::ZW-1:0]  in_z,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output fda_pkg::fda_ctl_t                                out_ctl,
  output logic [fda_pkg::LANES-1:0][W-1:0]                 out_u,
  output logic [fda_pkg::LANES-1:0][W-1:0]                 out_v,
  output logic [fda_pkg::LANES-1:0][fda_pkg::ZW-1:0]       out_z
);
  import fda_pkg::*;

  localparam logic [ZW-1:0] ANG = ZW'(ATAN_TAB[IDX]);

  logic                     valid_r;
  logic signed [W-1:0]      uu, vv, du, dv;
  logic [LANES-1:0][W-1:0]  u_nxt, v_nxt;
  logic [LANES-1:0][ZW-1:0] z_nxt;

  assign in_ready = !valid_r || out_ready;

  // One micro-rotation on all three lanes; both updates use the old values.
  always_comb begin
    uu = '0;
    vv = '0;
    du = '0;
    dv = '0;
    for (int k = 0; k < LANES; k++) begin
      uu = $signed(in_u[k]);
      vv = $signed(in_v[k]);
      du = vv >>> IDX;
      dv = uu >>> IDX;
      if (!vv[W-1]) begin
        u_nxt[k] = uu + du;
        v_nxt[k] = vv - dv;
        z_nxt[k] = in_z[k] + ANG;
      end else begin
        u_nxt[k] = uu - du;
        v_nxt[k] = vv + dv;
        z_nxt[k] = in_z[k] - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_ctl <= in_ctl;
      out_u   <= u_nxt;
      out_v   <= v_nxt;
      out_z   <= z_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

/* hdl/fda_post.sv */
`default_nettype none

module fda_post (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire fda_pkg::fda_ctl_t                           in_ctl,
  input  wire logic [fda_pkg::LANES-1:0][fda_pkg::ZW-1:0]  in_z,
  fda_out_if.source                                        out_ch
);
  import fda_pkg::*;

  logic                     valid_r;
  logic [LANES-1:0][ZW-1:0] zpos;
  logic [LANES-1:0][ZW-1:0] rnd;
  logic [LANES-1:0][QW-1:0] q;
  logic [LANES-1:0][AW-1:0] ang_nxt;
  logic [LANES-1:0][AW-1:0] ang_r;
  logic                     pv_r;

  assign in_ready = !valid_r || out_ch.ready;

  // Wrap into 0..360 degrees, round to 1/128 degree, fold 360 back to 0.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      zpos[k] = in_z[k][ZW-1] ? (in_z[k] + DEG360) : in_z[k];
      rnd[k]  = zpos[k] + RND_HALF;
      q[k]    = rnd[k][ZW-1:9];
      if (q[k] >= WRAP) begin
        q[k] = q[k] - WRAP;
      end
      if (!in_ctl.pv || in_ctl.zero[k]) begin
        ang_nxt[k] = '0;
      end else begin
        ang_nxt[k] = q[k][AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ang_r <= ang_nxt;
      pv_r  <= in_ctl.pv;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.angle_yz     = ang_r[0];
  assign out_ch.angle_xz     = ang_r[1];
  assign out_ch.angle_xy     = ang_r[2];
  assign out_ch.result_valid = pv_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pv_r |-> (ang_r[0] == '0) && (ang_r[1] == '0) && (ang_r[2] == '0))
    else $error("invalid sample produced a nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (ang_r[0] < WRAP[AW-1:0]) && (ang_r[1] < WRAP[AW-1:0])
                && (ang_r[2] < WRAP[AW-1:0]))
    else $error("angle outside 0..360 degrees");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !valid_r)
    else $error("output register valid after reset");

endmodule

`default_nettype wire

/* hdl/force_direction_angles.sv */
`default_nettype none
// An accepted input transaction reaches its result through one input register, one
// register per micro-rotation and one rounding/output register.
// Throughput: one transaction per cycle while out_ch.ready is high; every stage holds its
// own valid bit, so bubbles collapse and a stalled output only holds the stages that are full.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.

module force_direction_angles #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fda_in_if.sink     in_ch,
  fda_out_if.source  out_ch
);
  import fda_pkg::*;

  // Datapath width: the sample, one bit for negating the most negative value,
  // the guard bits from scaling by 2^CORDIC_STEPS, and two bits for the CORDIC
  // gain of about 1.65 on a vector up to sqrt(2) times the full scale.
  localparam int W = SAMPLE_WIDTH + CORDIC_STEPS + 3;

  // Stage k of these arrays is the output of register stage k; stage 0 is the
  // input register that holds the pre-rotated, scaled vectors.
  logic                     vld [CORDIC_STEPS+1];
  logic                     rdy [CORDIC_STEPS+1];
  fda_ctl_t                 ctl [CORDIC_STEPS+1];
  logic [LANES-1:0][W-1:0]  u   [CORDIC_STEPS+1];
  logic [LANES-1:0][W-1:0]  v   [CORDIC_STEPS+1];
  logic [LANES-1:0][ZW-1:0] z   [CORDIC_STEPS+1];

  // The input register sign-extends the three samples, builds the three lanes
  // (yOz, xOz, xOy), folds a vector in the left half-plane over by 180 degrees
  // and flags a zero vector, whose angle is forced to 0 at the end.
  fda_pre #(
    .SW    (SAMPLE_WIDTH),
    .W     (W),
    .STEPS (CORDIC_STEPS)
  ) u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_ctl   (ctl[0]),
    .out_u     (u[0]),
    .out_v     (v[0]),
    .out_z     (z[0])
  );

  // One registered micro-rotation per step, shared by the three lanes of a
  // transaction. The rotation direction follows the sign of v so that v is
  // driven toward zero while the angle collects the arctangent of each step.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    fda_step #(
      .W   (W),
      .IDX (g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_ctl    (ctl[g]),
      .in_u      (u[g]),
      .in_v      (v[g]),
      .in_z      (z[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_ctl   (ctl[g+1]),
      .out_u     (u[g+1]),
      .out_v     (v[g+1]),
      .out_z     (z[g+1])
    );
  end

  // The last register brings each angle into 0..360 degrees, rounds it to
  // 1/128 degree and zeroes it for a zero vector or an invalid sample. The
  // vector magnitudes are no longer needed there.
  fda_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld[CORDIC_STEPS]),
    .in_ready (rdy[CORDIC_STEPS]),
    .in_ctl   (ctl[CORDIC_STEPS]),
    .in_z     (z[CORDIC_STEPS]),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
